// ===== rtl/core/mheap_pkg.sv =====
package mheap_pkg;

   localparam int CAPACITY = 512;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 10;

   localparam logic [KIND_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [KIND_W-1:0] OP_EXTRACT = 2'd1;
   localparam logic [KIND_W-1:0] OP_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam int CMD_W = 4;
   localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ACC_INS   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_ACC_FULL  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_ACC_EMPTY = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ACC_OK    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_UP_RD     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_UP_MOVE   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_PUT       = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PK_LD     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_EX_LD     = 4'd9;
   localparam logic [CMD_W-1:0] CMD_DN_RD     = 4'd10;
   localparam logic [CMD_W-1:0] CMD_DN_MOVE   = 4'd11;
   localparam logic [CMD_W-1:0] CMD_PUBLISH   = 4'd12;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    out_key;
      logic [VALUE_W-1:0]  out_value;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic cnt_one;
      logic at_root;
      logic left_out;
      logic up_less;
      logic dn_less;
   } stat_type;

endpackage

// ===== rtl/core/binary_min_heap_priority_queue_top.sv =====
// Binary min-heap priority queue of (key, value) entries, smallest value served first,
// holding up to mheap_pkg::CAPACITY entries in a single on-chip memory with one write
// port and two registered read ports. One item is worked on at a time. An insert is
// accepted and climbs one level per sift pass until it is not smaller than its parent
// or reaches the root; an extract loads the root as its result and, unless that empties
// the heap, sinks the last entry down from the root; a peek loads the root; and a
// full insert, an empty extract or peek, or an unused kind only publishes its status.
// The sift loop does one memory read and one compare-and-write-back per level; for
// 512 entries an insert can climb at most 9 levels to the root. The finished result
// sits in an output register, so the next item is accepted while it waits to be taken.
module binary_min_heap_priority_queue_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mheap_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mheap_pkg::rsp_type  rsp_data
);

   mheap_pkg::ctrl_type ctrl;
   mheap_pkg::stat_type stat;

   mheap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mheap_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/mheap_dp.sv =====
module mheap_dp (
   input  logic               clock,
   input  logic               reset,
   input  mheap_pkg::ctrl_type ctrl,
   input  mheap_pkg::req_type  req_data,
   output mheap_pkg::stat_type stat,
   output mheap_pkg::rsp_type  rsp_data
);

   localparam int CW = mheap_pkg::ADDR_W + 2;

   mheap_pkg::entry_type mem_ff [mheap_pkg::CAPACITY];

   mheap_pkg::entry_type                  cur_ff, cur_in;
   logic [mheap_pkg::ADDR_W-1:0]          idx_ff, idx_in;
   logic [mheap_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [mheap_pkg::STATUS_W-1:0]        res_status_ff, res_status_in;
   mheap_pkg::entry_type                  res_ent_ff, res_ent_in;
   mheap_pkg::rsp_type                    rsp_ff, rsp_in;
   mheap_pkg::entry_type                  rd_a_ff, rd_b_ff;

   logic [mheap_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b, waddr, parent, child_idx;
   logic                         we;
   mheap_pkg::entry_type         wdata, child;
   logic [CW-1:0]                left_w, right_w, cnt_w;
   logic                         take_right;

   assign left_w     = CW'({idx_ff, 1'b1});
   assign right_w    = left_w + CW'(1);
   assign cnt_w      = CW'(cnt_ff);
   assign parent     = mheap_pkg::ADDR_W'((idx_ff - mheap_pkg::ADDR_W'(1)) >> 1);
   assign take_right = (right_w < cnt_w) && (rd_b_ff.value < rd_a_ff.value);
   assign child      = take_right ? rd_b_ff : rd_a_ff;
   assign child_idx  = take_right ? right_w[mheap_pkg::ADDR_W-1:0]
                                  : left_w[mheap_pkg::ADDR_W-1:0];

   assign stat.full     = cnt_ff >= mheap_pkg::CNT_W'(mheap_pkg::CAPACITY);
   assign stat.empty    = cnt_ff == '0;
   assign stat.cnt_one  = cnt_ff == mheap_pkg::CNT_W'(1);
   assign stat.at_root  = idx_ff == '0;
   assign stat.left_out = left_w >= cnt_w;
   assign stat.up_less  = cur_ff.value < rd_a_ff.value;
   assign stat.dn_less  = child.value < cur_ff.value;

   assign rsp_data = rsp_ff;

   always_comb begin
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_ent_in    = res_ent_ff;
      rsp_in        = rsp_ff;
      rd_addr_a     = '0;
      rd_addr_b     = mheap_pkg::ADDR_W'(cnt_ff - mheap_pkg::CNT_W'(1));
      we            = 1'b0;
      waddr         = idx_ff;
      wdata         = cur_ff;
      unique case (ctrl.op)
         mheap_pkg::CMD_NONE: begin
         end
         mheap_pkg::CMD_ACC_INS: begin
            cur_in.key    = req_data.key;
            cur_in.value  = req_data.value;
            idx_in        = cnt_ff[mheap_pkg::ADDR_W-1:0];
            cnt_in        = cnt_ff + mheap_pkg::CNT_W'(1);
            res_status_in = mheap_pkg::ST_OK;
            res_ent_in    = '0;
         end
         mheap_pkg::CMD_ACC_FULL: begin
            res_status_in = mheap_pkg::ST_FULL;
            res_ent_in    = '0;
         end
         mheap_pkg::CMD_ACC_EMPTY: begin
            res_status_in = mheap_pkg::ST_EMPTY;
            res_ent_in    = '0;
         end
         mheap_pkg::CMD_ACC_OK: begin
            res_status_in = mheap_pkg::ST_OK;
            res_ent_in    = '0;
         end
         mheap_pkg::CMD_UP_RD: begin
            rd_addr_a = parent;
         end
         mheap_pkg::CMD_UP_MOVE: begin
            we     = 1'b1;
            wdata  = rd_a_ff;
            idx_in = parent;
         end
         mheap_pkg::CMD_PUT: begin
            we = 1'b1;
         end
         mheap_pkg::CMD_PK_LD: begin
            res_ent_in = rd_a_ff;
         end
         mheap_pkg::CMD_EX_LD: begin
            res_ent_in = rd_a_ff;
            cur_in     = rd_b_ff;
            cnt_in     = cnt_ff - mheap_pkg::CNT_W'(1);
            idx_in     = '0;
         end
         mheap_pkg::CMD_DN_RD: begin
            rd_addr_a = left_w[mheap_pkg::ADDR_W-1:0];
            rd_addr_b = right_w[mheap_pkg::ADDR_W-1:0];
         end
         mheap_pkg::CMD_DN_MOVE: begin
            we     = 1'b1;
            wdata  = child;
            idx_in = child_idx;
         end
         mheap_pkg::CMD_PUBLISH: begin
            rsp_in.status    = res_status_ff;
            rsp_in.out_key   = res_ent_ff.key;
            rsp_in.out_value = res_ent_ff.value;
            rsp_in.count     = mheap_pkg::COUNT_W'(cnt_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_ent_ff    <= res_ent_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/core/mheap_ctrl.sv =====
module mheap_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [mheap_pkg::KIND_W-1:0]   req_kind,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  mheap_pkg::stat_type            stat,
   output mheap_pkg::ctrl_type            ctrl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP_CHK = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_PK     = 3'd3;
   localparam logic [2:0] S_EX     = 3'd4;
   localparam logic [2:0] S_DN_CHK = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctrl.op      = mheap_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind) inside
                  mheap_pkg::OP_INSERT: begin
                     if (stat.full) begin
                        ctrl.op  = mheap_pkg::CMD_ACC_FULL;
                        state_in = S_FIN;
                     end else begin
                        ctrl.op  = mheap_pkg::CMD_ACC_INS;
                        state_in = S_UP_CHK;
                     end
                  end
                  mheap_pkg::OP_EXTRACT, mheap_pkg::OP_PEEK: begin
                     if (stat.empty) begin
                        ctrl.op  = mheap_pkg::CMD_ACC_EMPTY;
                        state_in = S_FIN;
                     end else begin
                        ctrl.op  = mheap_pkg::CMD_ACC_OK;
                        state_in = (req_kind == mheap_pkg::OP_EXTRACT) ? S_EX : S_PK;
                     end
                  end
                  default: begin
                     ctrl.op  = mheap_pkg::CMD_ACC_OK;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_UP_CHK: begin
            if (stat.at_root) begin
               ctrl.op  = mheap_pkg::CMD_PUT;
               state_in = S_FIN;
            end else begin
               ctrl.op  = mheap_pkg::CMD_UP_RD;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_less) begin
               ctrl.op  = mheap_pkg::CMD_UP_MOVE;
               state_in = S_UP_CHK;
            end else begin
               ctrl.op  = mheap_pkg::CMD_PUT;
               state_in = S_FIN;
            end
         end
         S_PK: begin
            ctrl.op  = mheap_pkg::CMD_PK_LD;
            state_in = S_FIN;
         end
         S_EX: begin
            ctrl.op  = mheap_pkg::CMD_EX_LD;
            state_in = stat.cnt_one ? S_FIN : S_DN_CHK;
         end
         S_DN_CHK: begin
            if (stat.left_out) begin
               ctrl.op  = mheap_pkg::CMD_PUT;
               state_in = S_FIN;
            end else begin
               ctrl.op  = mheap_pkg::CMD_DN_RD;
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.dn_less) begin
               ctrl.op  = mheap_pkg::CMD_DN_MOVE;
               state_in = S_DN_CHK;
            end else begin
               ctrl.op  = mheap_pkg::CMD_PUT;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.op      = mheap_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/mheap_chk.sv =====
module mheap_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input mheap_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted before the first finished");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.count) <= mheap_pkg::CAPACITY)
      else $error("count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mheap_pkg::ST_FULL |->
         rsp_data.count == mheap_pkg::COUNT_W'(mheap_pkg::CAPACITY)
         && rsp_data.out_key == '0 && rsp_data.out_value == '0)
      else $error("full status with wrong count or payload");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mheap_pkg::ST_EMPTY |->
         rsp_data.count == '0 && rsp_data.out_key == '0 && rsp_data.out_value == '0)
      else $error("empty status with nonzero count or payload");

endmodule

bind binary_min_heap_priority_queue_top mheap_chk u_mheap_chk (.*);
